// ----- sv/obrf_pkg.sv -----
// Package for the overwriting byte ring FIFO.
// Holds the operation codes, the fixed field widths, the reset defaults and the per-beat result flags.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package obrf_pkg;

    // Fixed field widths.
    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int CNT_W       = 8;
    localparam int RING_SIZE_W = 9;

    // Default storage depth and ring size after reset.
    localparam int DEPTH_DEFAULT   = 256;
    localparam int RING_SIZE_RESET = 256;

    // Operation codes carried in the kind field.
    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH     = 3'd0,
        KIND_POP      = 3'd1,
        KIND_PEEK_OLD = 3'd2,
        KIND_PEEK_NEW = 3'd3,
        KIND_CLEAR    = 3'd4
    } kind_t;

    // Result of one operation, apart from the byte that comes from the store.
    typedef struct packed {
        logic [CNT_W-1:0] fill_count;
        logic             is_empty;
        logic             empty_error;
        logic             dropped_oldest;
        logic             use_rdata;
    } res_flags_t;

endpackage : obrf_pkg

`default_nettype wire

// ----- sv/obrf_mem.sv -----
// Byte store of the ring FIFO: a single-port synchronous RAM.
// At most one write and one read per cycle, read data registered.
// Uses obrf_pkg for the byte width.
`timescale 1ns / 1ps
`default_nettype none

module obrf_mem #(
    parameter int DEPTH = obrf_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic                       re,
    input  wire logic [AW-1:0]              addr,
    input  wire logic [obrf_pkg::BYTE_W-1:0] wdata,
    output logic      [obrf_pkg::BYTE_W-1:0] rdata
);
    import obrf_pkg::*;

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    // Write port and registered read port share one address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule : obrf_mem

`default_nettype wire

// ----- sv/obrf_ctrl.sv -----
// Index control of the ring FIFO: read and write indices, ring size, and the
// store access and result flags for each accepted beat.
// Uses obrf_pkg for operation codes and the result flag struct.
`timescale 1ns / 1ps
`default_nettype none

module obrf_ctrl #(
    parameter int DEPTH = obrf_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_accept,
    input  wire logic [obrf_pkg::KIND_W-1:0]      kind,
    input  wire logic [obrf_pkg::BYTE_W-1:0]      push_byte,
    input  wire logic                            cfg_we,
    input  wire logic [obrf_pkg::RING_SIZE_W-1:0] ring_size,
    output logic                                 mem_we,
    output logic                                 mem_re,
    output logic      [AW-1:0]                   mem_addr,
    output logic      [obrf_pkg::BYTE_W-1:0]      mem_wdata,
    output obrf_pkg::res_flags_t                 res
);
    import obrf_pkg::*;

    // Size arithmetic must hold both DEPTH and any ring_size value.
    localparam int SZ_W = (AW + 1 > RING_SIZE_W) ? AW + 1 : RING_SIZE_W;
    localparam logic [SZ_W-1:0] DEPTH_SZ  = SZ_W'(DEPTH);
    localparam logic [SZ_W-1:0] SIZE_RST  =
        (DEPTH < RING_SIZE_RESET) ? SZ_W'(DEPTH) : SZ_W'(RING_SIZE_RESET);
    localparam logic [AW-1:0]   LAST_RST  = AW'(SIZE_RST - SZ_W'(1));

    logic [AW-1:0]   wr_idx_reg, wr_idx_next;
    logic [AW-1:0]   rd_idx_reg, rd_idx_next;
    logic [SZ_W-1:0] size_reg,   size_next;
    logic [AW-1:0]   last_reg,   last_next;

    logic [SZ_W-1:0] size_raw;
    logic [AW-1:0]   wr_adv;
    logic [AW-1:0]   rd_adv;
    logic [AW-1:0]   newest_addr;
    logic            empty_now;
    logic [SZ_W-1:0] wr_ext;
    logic [SZ_W-1:0] rd_ext;
    logic [SZ_W-1:0] cnt_full;
    kind_t           op;

    assign op = kind_t'(kind);

    // Wrapping increments and the slot of the newest byte.
    assign wr_adv      = (wr_idx_reg == last_reg) ? '0 : wr_idx_reg + AW'(1);
    assign rd_adv      = (rd_idx_reg == last_reg) ? '0 : rd_idx_reg + AW'(1);
    assign newest_addr = (wr_idx_reg == '0) ? last_reg : wr_idx_reg - AW'(1);
    assign empty_now   = (wr_idx_reg == rd_idx_reg);

    // Clamp a written ring size into the range one to DEPTH.
    always_comb
    begin
        size_raw = SZ_W'(ring_size);
        if (size_raw == '0)
        begin
            size_raw = SZ_W'(1);
        end
        if (size_raw > DEPTH_SZ)
        begin
            size_raw = DEPTH_SZ;
        end
    end

    // Next indices, store access and flags for the beat being accepted.
    always_comb
    begin
        wr_idx_next        = wr_idx_reg;
        rd_idx_next        = rd_idx_reg;
        size_next          = size_reg;
        last_next          = last_reg;
        mem_we             = 1'b0;
        mem_re             = 1'b0;
        mem_addr           = rd_idx_reg;
        mem_wdata          = push_byte;
        res.empty_error    = 1'b0;
        res.dropped_oldest = 1'b0;
        res.use_rdata      = 1'b0;

        if (cfg_we)
        begin
            size_next   = size_raw;
            last_next   = AW'(size_raw - SZ_W'(1));
            wr_idx_next = '0;
            rd_idx_next = '0;
        end
        else if (item_accept)
        begin
            unique case (op)
                KIND_PUSH:
                begin
                    mem_we      = 1'b1;
                    mem_addr    = wr_idx_reg;
                    wr_idx_next = wr_adv;
                    if (wr_adv == rd_idx_reg)
                    begin
                        rd_idx_next        = rd_adv;
                        res.dropped_oldest = 1'b1;
                    end
                end
                KIND_POP, KIND_PEEK_OLD:
                begin
                    if (empty_now)
                    begin
                        res.empty_error = 1'b1;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        res.use_rdata = 1'b1;
                        if (op == KIND_POP)
                        begin
                            rd_idx_next = rd_adv;
                        end
                    end
                end
                KIND_PEEK_NEW:
                begin
                    if (empty_now)
                    begin
                        res.empty_error = 1'b1;
                    end
                    else
                    begin
                        mem_re        = 1'b1;
                        mem_addr      = newest_addr;
                        res.use_rdata = 1'b1;
                    end
                end
                KIND_CLEAR:
                begin
                    wr_idx_next = '0;
                    rd_idx_next = '0;
                end
                default:
                begin
                    // Unknown operation: state unchanged.
                end
            endcase
        end

        // Fill level and empty state after the operation.
        wr_ext   = SZ_W'(wr_idx_next);
        rd_ext   = SZ_W'(rd_idx_next);
        cnt_full = (wr_ext >= rd_ext) ? wr_ext - rd_ext : wr_ext + size_reg - rd_ext;
        res.fill_count = cnt_full[CNT_W-1:0];
        res.is_empty   = (wr_idx_next == rd_idx_next);
    end

    // Index and size registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg <= '0;
            rd_idx_reg <= '0;
            size_reg   <= SIZE_RST;
            last_reg   <= LAST_RST;
        end
        else
        begin
            wr_idx_reg <= wr_idx_next;
            rd_idx_reg <= rd_idx_next;
            size_reg   <= size_next;
            last_reg   <= last_next;
        end
    end

endmodule : obrf_ctrl

`default_nettype wire

// ----- sv/overwriting_byte_ring_fifo_core.sv -----
// Top level of the overwriting byte ring FIFO.
// Instantiates obrf_ctrl and obrf_mem and holds the result pipeline; uses obrf_pkg.
//
//  Channel | Signals                                            | Direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid, in_stall, kind, push_byte                 | input beat
//  out     | out_valid, out_stall, read_byte, fill_count,        | result beat
//          | is_empty, empty_error, dropped_oldest               |
//  cfg     | cfg_valid, cfg_ready, ring_size                     | register write
//
// One beat is accepted per cycle while in_stall is low. Each result passes through
// the pending stage, beside the registered store read, and then the output register.
// Indices update at acceptance, so a byte pushed is visible to the next beat.
// Reset empties the ring and sets the ring size to 256 (or DEPTH if smaller);
// the store contents are not cleared and need no clearing pass.
// While a result waits under out_stall with another behind it, in_stall is raised.
`timescale 1ns / 1ps
`default_nettype none

module overwriting_byte_ring_fifo_core #(
    parameter int DEPTH = obrf_pkg::DEPTH_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [obrf_pkg::KIND_W-1:0]      kind,
    input  wire logic [obrf_pkg::BYTE_W-1:0]      push_byte,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic      [obrf_pkg::BYTE_W-1:0]      read_byte,
    output logic      [obrf_pkg::CNT_W-1:0]       fill_count,
    output logic                                 is_empty,
    output logic                                 empty_error,
    output logic                                 dropped_oldest,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [obrf_pkg::RING_SIZE_W-1:0] ring_size
);
    import obrf_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic              accept;
    logic              out_free;
    logic              cfg_we;
    logic              mem_we;
    logic              mem_re;
    logic [AW-1:0]     mem_addr;
    logic [BYTE_W-1:0] mem_wdata;
    logic [BYTE_W-1:0] mem_rdata;
    res_flags_t        res;

    logic              pend_valid_reg, pend_valid_next;
    res_flags_t        pend_res_reg;
    logic              out_valid_reg,  out_valid_next;
    logic [BYTE_W-1:0] read_byte_reg;
    logic [CNT_W-1:0]  fill_count_reg;
    logic              is_empty_reg;
    logic              empty_error_reg;
    logic              dropped_oldest_reg;

    // Handshakes: the pending stage moves whenever the output register frees up.
    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = pend_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    obrf_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_accept (accept),
        .kind        (kind),
        .push_byte   (push_byte),
        .cfg_we      (cfg_we),
        .ring_size   (ring_size),
        .mem_we      (mem_we),
        .mem_re      (mem_re),
        .mem_addr    (mem_addr),
        .mem_wdata   (mem_wdata),
        .res         (res)
    );

    obrf_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    // Valid bits of the pending stage and the output register.
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg;
        if (out_free)
        begin
            out_valid_next  = pend_valid_reg;
            pend_valid_next = 1'b0;
        end
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload of the pending stage and the output register.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_res_reg <= res;
        end
        if (out_free && pend_valid_reg)
        begin
            read_byte_reg      <= pend_res_reg.use_rdata ? mem_rdata : '0;
            fill_count_reg     <= pend_res_reg.fill_count;
            is_empty_reg       <= pend_res_reg.is_empty;
            empty_error_reg    <= pend_res_reg.empty_error;
            dropped_oldest_reg <= pend_res_reg.dropped_oldest;
        end
    end

    assign out_valid      = out_valid_reg;
    assign read_byte      = read_byte_reg;
    assign fill_count     = fill_count_reg;
    assign is_empty       = is_empty_reg;
    assign empty_error    = empty_error_reg;
    assign dropped_oldest = dropped_oldest_reg;

endmodule : overwriting_byte_ring_fifo_core

`default_nettype wire
